FILE: sv/wha_pkg.sv
package wha_pkg;

   localparam int MAX_BINS    = 256;
   localparam int STORE_DEPTH = MAX_BINS + 2;
   localparam int BIN_W       = $clog2(STORE_DEPTH);

   localparam int ENERGY_W = 32;
   localparam int WEIGHT_W = 24;
   localparam int WSUM_W   = 48;
   localparam int SQ_W     = 63;
   localparam int SQPROD_W = 2 * WEIGHT_W - 1;
   localparam int CNT_W    = 9;
   localparam int DIV_W    = ENERGY_W + BIN_W;
   localparam int STEP_W   = $clog2(BIN_W);

   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
   localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
   localparam logic [1:0] REG_BIN_COUNT  = 2'd2;

   localparam logic OP_FILL = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic signed [ENERGY_W-1:0] RANGE_LOW_RESET  = 32'sd0;
   localparam logic signed [ENERGY_W-1:0] RANGE_HIGH_RESET = 32'sd65536;
   localparam logic [CNT_W-1:0]           BIN_COUNT_RESET  = 9'd64;
   localparam logic signed [ENERGY_W-1:0] MIN_ENERGY_RESET = 32'sh7FFF_FFFF;

   localparam logic signed [WSUM_W-1:0] WSUM_MAX = {1'b0, {(WSUM_W-1){1'b1}}};
   localparam logic signed [WSUM_W-1:0] WSUM_MIN = {1'b1, {(WSUM_W-1){1'b0}}};
   localparam logic [SQ_W-1:0]          SQ_MAX   = {SQ_W{1'b1}};

   typedef struct packed {
      logic signed [WSUM_W-1:0] wsum;
      logic [SQ_W-1:0]          sq;
   } entry_type;

endpackage

FILE: sv/weighted_histogram_accumulator.sv
// sequence: reads and out-of-range fills pass PREP, READ and UPDATE before the result is
// registered; fills inside the range also pass DIV, waiting there on the divider
// one transaction at a time: the input stalls until the sequencer is idle again; the
// 9-step serial divider that finds the bin makes in-range fills the longer case
// reset: synchronous; a clearing pass zeroes all 258 bin store entries, input stalled
module weighted_histogram_accumulator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic signed [wha_pkg::ENERGY_W-1:0] req_energy,
   input  logic signed [wha_pkg::WEIGHT_W-1:0] req_weight,
   input  logic [wha_pkg::BIN_W-1:0]           req_read_bin,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [wha_pkg::BIN_W-1:0]           rsp_bin_number,
   output logic signed [wha_pkg::WSUM_W-1:0]   rsp_bin_weight_sum,
   output logic [wha_pkg::SQ_W-1:0]            rsp_bin_square_sum,
   output logic signed [wha_pkg::ENERGY_W-1:0] rsp_largest_seen,
   output logic signed [wha_pkg::ENERGY_W-1:0] rsp_smallest_seen,
   output logic                                rsp_saturated,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [wha_pkg::ADDR_W-1:0]          paddr,
   input  logic [wha_pkg::DATA_W-1:0]          pwdata,
   output logic [wha_pkg::DATA_W-1:0]          prdata,
   output logic                                pready
);

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_CLEAR  = 3'd0;
   localparam logic [ST_W-1:0] ST_IDLE   = 3'd1;
   localparam logic [ST_W-1:0] ST_PREP   = 3'd2;
   localparam logic [ST_W-1:0] ST_DIV    = 3'd3;
   localparam logic [ST_W-1:0] ST_READ   = 3'd4;
   localparam logic [ST_W-1:0] ST_UPDATE = 3'd5;

   // configuration
   logic signed [wha_pkg::ENERGY_W-1:0] range_low_ff;
   logic signed [wha_pkg::ENERGY_W-1:0] range_high_ff;
   logic [wha_pkg::CNT_W-1:0]           bin_count_ff;
   logic                                csr_write;
   logic [1:0]                          csr_index;

   // sequencer and item
   logic [ST_W-1:0]                     state_ff, state_in;
   logic [wha_pkg::BIN_W-1:0]           clr_ff, clr_in;
   logic [wha_pkg::BIN_W-1:0]           bin_ff, bin_in;
   logic                                op_ff;
   logic signed [wha_pkg::ENERGY_W-1:0] energy_ff;
   logic signed [wha_pkg::WEIGHT_W-1:0] weight_ff;
   logic [wha_pkg::BIN_W-1:0]           read_bin_ff;
   logic [wha_pkg::SQPROD_W-1:0]        sq_ff;
   logic signed [wha_pkg::ENERGY_W-1:0] max_ff;
   logic signed [wha_pkg::ENERGY_W-1:0] min_ff;

   // output register
   logic                                rsp_valid_ff;
   logic [wha_pkg::BIN_W-1:0]           rsp_bin_ff;
   logic signed [wha_pkg::WSUM_W-1:0]   rsp_wsum_ff;
   logic [wha_pkg::SQ_W-1:0]            rsp_sq_ff;
   logic signed [wha_pkg::ENERGY_W-1:0] rsp_max_ff;
   logic signed [wha_pkg::ENERGY_W-1:0] rsp_min_ff;
   logic                                rsp_sat_ff;

   logic                                accept;
   logic                                is_fill;
   logic [wha_pkg::BIN_W-1:0]           n_eff;
   logic [wha_pkg::BIN_W-1:0]           n_top;
   logic                                below;
   logic                                above;
   logic signed [wha_pkg::ENERGY_W:0]   offset;
   logic [wha_pkg::DIV_W-1:0]           dividend;
   logic [wha_pkg::ENERGY_W-1:0]        divisor;
   logic signed [2*wha_pkg::WEIGHT_W-1:0] weight_sq;
   logic [wha_pkg::BIN_W-1:0]           read_clamp;
   logic                                div_start;
   logic                                div_done;
   logic [wha_pkg::BIN_W-1:0]           div_quotient;

   wha_pkg::entry_type                  rd_entry;
   wha_pkg::entry_type                  new_entry;
   wha_pkg::entry_type                  wr_entry;
   logic                                wr_en;
   logic [wha_pkg::BIN_W-1:0]           wr_addr;
   logic                                rd_en;
   logic signed [wha_pkg::WSUM_W:0]     wsum_sum;
   logic [wha_pkg::SQ_W:0]              sq_sum;
   logic                                wsum_hi;
   logic                                wsum_lo;
   logic                                sat;
   logic signed [wha_pkg::ENERGY_W-1:0] max_new;
   logic signed [wha_pkg::ENERGY_W-1:0] min_new;
   logic                                slot_free;
   logic                                fire;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[wha_pkg::ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= wha_pkg::RANGE_LOW_RESET;
         range_high_ff <= wha_pkg::RANGE_HIGH_RESET;
         bin_count_ff  <= wha_pkg::BIN_COUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            wha_pkg::REG_RANGE_LOW:  range_low_ff  <= pwdata;
            wha_pkg::REG_RANGE_HIGH: range_high_ff <= pwdata;
            wha_pkg::REG_BIN_COUNT:  bin_count_ff  <= pwdata[wha_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         wha_pkg::REG_RANGE_LOW:  prdata = range_low_ff;
         wha_pkg::REG_RANGE_HIGH: prdata = range_high_ff;
         wha_pkg::REG_BIN_COUNT:  prdata = wha_pkg::DATA_W'(bin_count_ff);
         default:                 prdata = '0;
      endcase
   end

   // ---------------- bin arithmetic ----------------
   always_comb begin
      if (bin_count_ff == '0) begin
         n_eff = wha_pkg::BIN_W'(1);
      end else if (int'(bin_count_ff) > wha_pkg::MAX_BINS) begin
         n_eff = wha_pkg::BIN_W'(wha_pkg::MAX_BINS);
      end else begin
         n_eff = wha_pkg::BIN_W'(bin_count_ff);
      end
   end

   assign n_top     = n_eff + 1'b1;
   assign is_fill   = op_ff == wha_pkg::OP_FILL;
   assign below     = energy_ff < range_low_ff;
   // an empty or inverted range sends everything not below to overflow
   assign above     = energy_ff >= range_high_ff;
   assign offset    = (wha_pkg::ENERGY_W+1)'(energy_ff) - (wha_pkg::ENERGY_W+1)'(range_low_ff);
   assign dividend  = wha_pkg::DIV_W'(offset[wha_pkg::ENERGY_W-1:0]) * wha_pkg::DIV_W'(n_eff);
   assign divisor   = range_high_ff - range_low_ff;
   assign weight_sq = weight_ff * weight_ff;
   assign read_clamp = (read_bin_ff > n_top) ? n_top : read_bin_ff;
   assign div_start = (state_ff == ST_PREP) && is_fill && !below && !above;

   wha_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // ---------------- read-modify-write ----------------
   assign wsum_sum = (wha_pkg::WSUM_W+1)'(rd_entry.wsum) + (wha_pkg::WSUM_W+1)'(weight_ff);
   assign sq_sum   = (wha_pkg::SQ_W+1)'(rd_entry.sq) + (wha_pkg::SQ_W+1)'(sq_ff);
   assign wsum_hi  = !wsum_sum[wha_pkg::WSUM_W] && wsum_sum[wha_pkg::WSUM_W-1];
   assign wsum_lo  = wsum_sum[wha_pkg::WSUM_W] && !wsum_sum[wha_pkg::WSUM_W-1];
   assign sat      = wsum_hi || wsum_lo || sq_sum[wha_pkg::SQ_W];

   always_comb begin
      if (wsum_hi) begin
         new_entry.wsum = wha_pkg::WSUM_MAX;
      end else if (wsum_lo) begin
         new_entry.wsum = wha_pkg::WSUM_MIN;
      end else begin
         new_entry.wsum = wsum_sum[wha_pkg::WSUM_W-1:0];
      end
      new_entry.sq = sq_sum[wha_pkg::SQ_W] ? wha_pkg::SQ_MAX : sq_sum[wha_pkg::SQ_W-1:0];
   end

   assign max_new = (energy_ff > max_ff) ? energy_ff : max_ff;
   assign min_new = (energy_ff < min_ff) ? energy_ff : min_ff;

   // result may wait in the output register while the next transaction comes in
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign fire      = (state_ff == ST_UPDATE) && slot_free;

   assign wr_en    = (state_ff == ST_CLEAR) || (fire && is_fill);
   assign wr_addr  = (state_ff == ST_CLEAR) ? clr_ff : bin_ff;
   assign wr_entry = (state_ff == ST_CLEAR) ? '0 : new_entry;
   assign rd_en    = state_ff == ST_READ;

   wha_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (bin_ff),
      .rd_data (rd_entry)
   );

   // ---------------- sequencer ----------------
   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      bin_in   = bin_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == wha_pkg::BIN_W'(wha_pkg::STORE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (!is_fill) begin
               bin_in   = read_clamp;
               state_in = ST_READ;
            end else if (below) begin
               bin_in   = '0;
               state_in = ST_READ;
            end else if (above) begin
               bin_in   = n_top;
               state_in = ST_READ;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               bin_in   = div_quotient + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         max_ff       <= '0;
         min_ff       <= wha_pkg::MIN_ENERGY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (fire && is_fill) begin
            max_ff <= max_new;
            min_ff <= min_new;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      if (accept) begin
         op_ff       <= req_op;
         energy_ff   <= req_energy;
         weight_ff   <= req_weight;
         read_bin_ff <= req_read_bin;
      end
      if (state_ff == ST_PREP) begin
         sq_ff <= weight_sq[wha_pkg::SQPROD_W-1:0];
      end
      if (fire) begin
         rsp_bin_ff  <= bin_ff;
         rsp_wsum_ff <= is_fill ? new_entry.wsum : rd_entry.wsum;
         rsp_sq_ff   <= is_fill ? new_entry.sq : rd_entry.sq;
         rsp_max_ff  <= is_fill ? max_new : max_ff;
         rsp_min_ff  <= is_fill ? min_new : min_ff;
         rsp_sat_ff  <= is_fill && sat;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_bin_number     = rsp_bin_ff;
   assign rsp_bin_weight_sum = rsp_wsum_ff;
   assign rsp_bin_square_sum = rsp_sq_ff;
   assign rsp_largest_seen   = rsp_max_ff;
   assign rsp_smallest_seen  = rsp_min_ff;
   assign rsp_saturated      = rsp_sat_ff;

endmodule

FILE: sv/wha_store.sv
module wha_store (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [wha_pkg::BIN_W-1:0] wr_addr,
   input  wha_pkg::entry_type        wr_data,
   input  logic                      rd_en,
   input  logic [wha_pkg::BIN_W-1:0] rd_addr,
   output wha_pkg::entry_type        rd_data
);

   wha_pkg::entry_type mem [wha_pkg::STORE_DEPTH];
   wha_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/wha_divider.sv
module wha_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [wha_pkg::DIV_W-1:0]    dividend,
   input  logic [wha_pkg::ENERGY_W-1:0] divisor,
   output logic                         done,
   output logic [wha_pkg::BIN_W-1:0]    quotient
);

   // quotient is known to fit in BIN_W bits, so only that many restoring steps
   logic                          busy_ff;
   logic                          done_ff;
   logic [wha_pkg::STEP_W-1:0]    cnt_ff;
   logic [wha_pkg::DIV_W-1:0]     rem_ff;
   logic [wha_pkg::DIV_W-1:0]     dsh_ff;
   logic [wha_pkg::BIN_W-1:0]     quo_ff;
   logic                          fits;
   logic [wha_pkg::DIV_W-1:0]     rem_sub;

   assign fits    = rem_ff >= dsh_ff;
   assign rem_sub = rem_ff - dsh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= wha_pkg::STEP_W'(wha_pkg::BIN_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
         dsh_ff <= wha_pkg::DIV_W'(divisor) << (wha_pkg::BIN_W - 1);
         quo_ff <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_sub;
         end
         dsh_ff <= dsh_ff >> 1;
         quo_ff <= {quo_ff[wha_pkg::BIN_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: sv/wha_checker.sv
module wha_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [wha_pkg::BIN_W-1:0]           rsp_bin_number,
   input logic signed [wha_pkg::WSUM_W-1:0]   rsp_bin_weight_sum,
   input logic [wha_pkg::SQ_W-1:0]            rsp_bin_square_sum,
   input logic signed [wha_pkg::ENERGY_W-1:0] rsp_largest_seen,
   input logic signed [wha_pkg::ENERGY_W-1:0] rsp_smallest_seen,
   input logic                                rsp_saturated
);

   // reset starts the clearing pass: nothing taken, nothing shown
   a_reset_clear: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("input open or result shown right after reset");

   // one transaction at a time: the sequencer closes the input after each one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction taken while one is in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bin_number)
         && $stable(rsp_bin_weight_sum) && $stable(rsp_bin_square_sum)
         && $stable(rsp_largest_seen) && $stable(rsp_smallest_seen)
         && $stable(rsp_saturated))
      else $error("stalled result changed or dropped");

   // the maximum starts at zero and only grows
   a_max_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_largest_seen[wha_pkg::ENERGY_W-1])
      else $error("largest energy below its reset value");

   a_extremes_monotonic: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) ##1 rsp_valid |->
         rsp_largest_seen >= $past(rsp_largest_seen)
         && rsp_smallest_seen <= $past(rsp_smallest_seen))
      else $error("energy extremes moved the wrong way");

endmodule

bind weighted_histogram_accumulator wha_checker u_wha_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int     QUIET_LIMIT   = 2000;
   localparam int     SETTLE_CYCLES = 20;
   localparam longint ENERGY_TOP    = 64'sd2147483647;
   localparam longint ENERGY_BOT    = -64'sd2147483648;

   typedef struct packed {
      logic [wha_pkg::BIN_W-1:0]           bin;
      logic signed [wha_pkg::WSUM_W-1:0]   wsum;
      logic [wha_pkg::SQ_W-1:0]            sq;
      logic signed [wha_pkg::ENERGY_W-1:0] largest;
      logic signed [wha_pkg::ENERGY_W-1:0] smallest;
      logic                                saturated;
   } bin_report_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic                                req_op = wha_pkg::OP_FILL;
   logic signed [wha_pkg::ENERGY_W-1:0] req_energy = '0;
   logic signed [wha_pkg::WEIGHT_W-1:0] req_weight = '0;
   logic [wha_pkg::BIN_W-1:0]           req_read_bin = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [wha_pkg::BIN_W-1:0]           rsp_bin_number;
   logic signed [wha_pkg::WSUM_W-1:0]   rsp_bin_weight_sum;
   logic [wha_pkg::SQ_W-1:0]            rsp_bin_square_sum;
   logic signed [wha_pkg::ENERGY_W-1:0] rsp_largest_seen;
   logic signed [wha_pkg::ENERGY_W-1:0] rsp_smallest_seen;
   logic                                rsp_saturated;
   logic                                psel = 1'b0;
   logic                                penable = 1'b0;
   logic                                pwrite = 1'b0;
   logic [wha_pkg::ADDR_W-1:0]          paddr = '0;
   logic [wha_pkg::DATA_W-1:0]          pwdata = '0;
   logic [wha_pkg::DATA_W-1:0]          prdata;
   logic                                pready;

   // histogram predictor state and its copy of the registers
   logic signed [wha_pkg::WSUM_W-1:0]   hist_wsum [wha_pkg::STORE_DEPTH];
   logic [wha_pkg::SQ_W-1:0]            hist_sq [wha_pkg::STORE_DEPTH];
   logic signed [wha_pkg::ENERGY_W-1:0] hist_max;
   logic signed [wha_pkg::ENERGY_W-1:0] hist_min;
   logic signed [wha_pkg::ENERGY_W-1:0] cfg_low;
   logic signed [wha_pkg::ENERGY_W-1:0] cfg_high;
   logic [wha_pkg::CNT_W-1:0]           cfg_bin_total;

   bin_report_type                      expected_reports [$];
   bin_report_type                      want;
   int                                  errors = 0;
   int                                  quiet_cycles = 0;
   int                                  stall_left = 0;
   bit                                  idle_enable = 1'b1;

   weighted_histogram_accumulator dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_energy         (req_energy),
      .req_weight         (req_weight),
      .req_read_bin       (req_read_bin),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_bin_number     (rsp_bin_number),
      .rsp_bin_weight_sum (rsp_bin_weight_sum),
      .rsp_bin_square_sum (rsp_bin_square_sum),
      .rsp_largest_seen   (rsp_largest_seen),
      .rsp_smallest_seen  (rsp_smallest_seen),
      .rsp_saturated      (rsp_saturated),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #5 clock = ~clock;

   function automatic int effective_bins();
      if (cfg_bin_total == 0) return 1;
      if (int'(cfg_bin_total) > wha_pkg::MAX_BINS) return wha_pkg::MAX_BINS;
      return int'(cfg_bin_total);
   endfunction

   function automatic bin_report_type apply_item(
         input logic op,
         input logic signed [wha_pkg::ENERGY_W-1:0] energy,
         input logic signed [wha_pkg::WEIGHT_W-1:0] weight,
         input logic [wha_pkg::BIN_W-1:0] read_bin);
      bin_report_type r;
      int             n;
      int             b;
      longint         lo;
      longint         hi;
      longint         x;
      longint         w;
      longint         s;
      logic [63:0]    w_sq;
      n = effective_bins();
      r.saturated = 1'b0;
      if (op == wha_pkg::OP_READ) begin
         b = (int'(read_bin) > n + 1) ? n + 1 : int'(read_bin);
      end else begin
         lo = cfg_low;
         hi = cfg_high;
         x  = energy;
         // an empty or inverted range sends everything not below range_low to overflow
         if (x < lo) b = 0;
         else if (x >= hi) b = n + 1;
         else b = int'((x - lo) * longint'(n) / (hi - lo)) + 1;
         w    = weight;
         w_sq = w * w;
         s    = longint'(hist_wsum[b]) + w;
         if (s > wha_pkg::WSUM_MAX) begin
            s = wha_pkg::WSUM_MAX;
            r.saturated = 1'b1;
         end else if (s < wha_pkg::WSUM_MIN) begin
            s = wha_pkg::WSUM_MIN;
            r.saturated = 1'b1;
         end
         hist_wsum[b] = s[wha_pkg::WSUM_W-1:0];
         if (64'(hist_sq[b]) > 64'(wha_pkg::SQ_MAX) - w_sq) begin
            hist_sq[b] = wha_pkg::SQ_MAX;
            r.saturated = 1'b1;
         end else begin
            hist_sq[b] = hist_sq[b] + w_sq[wha_pkg::SQ_W-1:0];
         end
         if (energy > hist_max) hist_max = energy;
         if (energy < hist_min) hist_min = energy;
      end
      r.bin      = wha_pkg::BIN_W'(b);
      r.wsum     = hist_wsum[b];
      r.sq       = hist_sq[b];
      r.largest  = hist_max;
      r.smallest = hist_min;
      return r;
   endfunction

   function automatic logic signed [wha_pkg::ENERGY_W-1:0] random_energy();
      longint lo;
      longint hi;
      longint pick;
      lo = cfg_low;
      hi = cfg_high;
      case ($urandom_range(0, 9))
         0: pick = int'($urandom);
         1: pick = lo - longint'($urandom_range(1, 4));
         2: pick = hi - longint'($urandom_range(0, 1));
         3: pick = lo + longint'($urandom_range(0, 1));
         default: begin
            if (hi > lo) pick = lo + longint'({$urandom, $urandom} >> 1) % (hi - lo);
            else pick = int'($urandom);
         end
      endcase
      if (pick > ENERGY_TOP) pick = ENERGY_TOP;
      if (pick < ENERGY_BOT) pick = ENERGY_BOT;
      return pick[wha_pkg::ENERGY_W-1:0];
   endfunction

   function automatic logic signed [wha_pkg::WEIGHT_W-1:0] random_weight();
      logic [31:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 9))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         2: return '0;
         default: return raw[wha_pkg::WEIGHT_W-1:0];
      endcase
   endfunction

   task automatic reset_model();
      for (int i = 0; i < wha_pkg::STORE_DEPTH; i++) begin
         hist_wsum[i] = '0;
         hist_sq[i]   = '0;
      end
      hist_max      = '0;
      hist_min      = wha_pkg::MIN_ENERGY_RESET;
      cfg_low       = wha_pkg::RANGE_LOW_RESET;
      cfg_high      = wha_pkg::RANGE_HIGH_RESET;
      cfg_bin_total = wha_pkg::BIN_COUNT_RESET;
   endtask

   // valid is left high after acceptance; the next call replaces the item or lowers it, and wait_idle lowers it
   task automatic send_item(input logic op,
                            input logic signed [wha_pkg::ENERGY_W-1:0] energy,
                            input logic signed [wha_pkg::WEIGHT_W-1:0] weight,
                            input logic [wha_pkg::BIN_W-1:0] read_bin);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_energy   <= energy;
      req_weight   <= weight;
      req_read_bin <= read_bin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_reports.insert(expected_reports.size(),
                              apply_item(op, energy, weight, read_bin));
   endtask

   task automatic fill_item(input logic signed [wha_pkg::ENERGY_W-1:0] energy,
                            input logic signed [wha_pkg::WEIGHT_W-1:0] weight);
      send_item(wha_pkg::OP_FILL, energy, weight, wha_pkg::BIN_W'($urandom_range(0, 511)));
   endtask

   task automatic read_item(input logic [wha_pkg::BIN_W-1:0] read_bin);
      send_item(wha_pkg::OP_READ, random_energy(), random_weight(), read_bin);
   endtask

   task automatic random_item();
      int n;
      n = effective_bins();
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 3))
            0: read_item(wha_pkg::BIN_W'(n + 1));
            1: read_item(wha_pkg::BIN_W'($urandom_range(0, 257)));
            default: read_item(wha_pkg::BIN_W'($urandom_range(0, n + 1)));
         endcase
      end else begin
         fill_item(random_energy(), random_weight());
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write one register, then read it straight back
   task automatic write_register(input logic [1:0] index,
                                 input logic [wha_pkg::DATA_W-1:0] value);
      logic [wha_pkg::DATA_W-1:0] stored;
      stored  = (index == wha_pkg::REG_BIN_COUNT) ? (value & 32'h1FF) : value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== stored) begin
         $error("register %0d readback: expected %h, actual %h", index, stored, prdata);
         errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      case (index)
         wha_pkg::REG_RANGE_LOW:  cfg_low = value;
         wha_pkg::REG_RANGE_HIGH: cfg_high = value;
         wha_pkg::REG_BIN_COUNT:  cfg_bin_total = stored[wha_pkg::CNT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(input logic signed [wha_pkg::ENERGY_W-1:0] lo,
                            input logic signed [wha_pkg::ENERGY_W-1:0] hi,
                            input logic [wha_pkg::CNT_W-1:0] bin_total);
      wait_idle();
      write_register(wha_pkg::REG_RANGE_LOW, lo);
      write_register(wha_pkg::REG_RANGE_HIGH, hi);
      write_register(wha_pkg::REG_BIN_COUNT, {23'b0, bin_total});
   endtask

   // reset values of the registers, extremes of energy and weight
   task automatic test_default_edges();
      read_item(9'd0);
      read_item(9'd257);
      fill_item(32'sd0, 24'sh7FFFFF);
      fill_item(32'sd65535, 24'sh800000);
      fill_item(32'sd65536, 24'sd1);
      fill_item(-32'sd1, -24'sd1);
      fill_item(32'sh7FFFFFFF, 24'sd0);
      fill_item(32'sh80000000, 24'sh7FFFFF);
      fill_item(32'sd1023, random_weight());
      fill_item(32'sd1024, random_weight());
      read_item(9'd1);
   endtask

   // bin counts of zero and above the maximum are clamped
   task automatic test_bin_count_limits();
      configure(32'sd0, 32'sd65536, 9'd1);
      fill_item(32'sd0, random_weight());
      fill_item(32'sd65535, random_weight());
      fill_item(32'sd65536, random_weight());
      read_item(9'd3);
      configure(32'sd0, 32'sd65536, 9'd0);
      fill_item(32'sd32768, random_weight());
      read_item(9'd257);
      configure(32'sd0, 32'sd65536, 9'd256);
      fill_item(32'sd65535, random_weight());
      read_item(9'd257);
      configure(32'sd0, 32'sd65536, 9'd511);
      fill_item(32'sd65535, random_weight());
      read_item(9'd257);
   endtask

   task automatic test_inverted_range();
      configure(32'sd100, 32'sd100, 9'd64);
      fill_item(32'sd99, random_weight());
      fill_item(32'sd100, random_weight());
      configure(32'sh7FFFFFFF, 32'sh80000000, 9'd8);
      fill_item(32'sh80000000, random_weight());
      fill_item(32'sh7FFFFFFF, random_weight());
      read_item(9'd257);
   endtask

   task automatic test_full_range();
      configure(32'sh80000000, 32'sh7FFFFFFF, 9'd256);
      fill_item(32'sh80000000, random_weight());
      fill_item(32'sh7FFFFFFE, random_weight());
      fill_item(32'sh7FFFFFFF, random_weight());
      repeat (60) random_item();
   endtask

   task automatic test_random_settings(input int phases, input int items_each);
      longint                    lo;
      longint                    hi;
      logic [wha_pkg::CNT_W-1:0] bin_total;
      for (int p = 0; p < phases; p++) begin
         lo = int'($urandom);
         if ($urandom_range(0, 7) == 0) hi = lo - longint'($urandom_range(0, 1000));
         else hi = lo + 1 + longint'($urandom >> $urandom_range(0, 31));
         if (hi > ENERGY_TOP) hi = ENERGY_TOP;
         if (hi < ENERGY_BOT) hi = ENERGY_BOT;
         case ($urandom_range(0, 9))
            0: bin_total = 9'd0;
            1: bin_total = wha_pkg::CNT_W'($urandom_range(257, 511));
            2: bin_total = 9'd1;
            3: bin_total = 9'd256;
            default: bin_total = wha_pkg::CNT_W'($urandom_range(2, 255));
         endcase
         configure(lo[wha_pkg::ENERGY_W-1:0], hi[wha_pkg::ENERGY_W-1:0], bin_total);
         idle_enable = ($urandom_range(0, 3) != 0);
         repeat (items_each) random_item();
      end
   endtask

   task automatic test_no_idling();
      configure(-32'sd1000, 32'sd1000, 9'd16);
      idle_enable = 1'b0;
      repeat (80) random_item();
   endtask

   initial begin
      reset_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_default_edges();
      test_bin_count_limits();
      test_inverted_range();
      test_full_range();
      test_random_settings(6, 80);
      test_no_idling();
      wait_idle();
      if (errors == 0) begin
         $display("weighted_histogram_accumulator regression: pass");
      end else begin
         $display("weighted_histogram_accumulator regression: fail");
      end
      $finish;
   end

   // receiver stalls in bursts of random length
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_enable && $urandom_range(0, 6) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= int'($urandom_range(0, 12));
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic check_field(input string name, input logic [63:0] expected,
                              input logic [63:0] actual);
      if (expected !== actual) begin
         $error("%s: expected %h, actual %h", name, expected, actual);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            $error("result transaction with no item outstanding, bin %0d", rsp_bin_number);
            errors++;
         end else begin
            want = expected_reports.pop_front();
            check_field("bin_number", 64'(want.bin), 64'(rsp_bin_number));
            check_field("bin_weight_sum", 64'(want.wsum), 64'(rsp_bin_weight_sum));
            check_field("bin_square_sum", 64'(want.sq), 64'(rsp_bin_square_sum));
            check_field("largest_seen", 64'(want.largest), 64'(rsp_largest_seen));
            check_field("smallest_seen", 64'(want.smallest), 64'(rsp_smallest_seen));
            check_field("saturated", 64'(want.saturated), 64'(rsp_saturated));
         end
      end
   end

   // covers the clearing pass after reset as well as ordinary stalls
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable && pready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("weighted_histogram_accumulator regression: fail");
         $finish;
      end
   end

endmodule
